// File: rtl/bc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every rtl module imports it.
`timescale 1ns / 1ps
package bc_pkg;

    localparam int C_DW = 32;

    // configuration register indexes
    localparam logic [2:0] C_REG_CAL_A   = 3'd0;
    localparam logic [2:0] C_REG_CAL_U   = 3'd1;
    localparam logic [2:0] C_REG_CAL_B   = 3'd2;
    localparam logic [2:0] C_REG_CAL_M   = 3'd3;
    localparam logic [2:0] C_REG_OSS     = 3'd4;

    localparam logic [31:0] C_B6_OFFSET  = 32'd4000;
    localparam logic [31:0] C_B4_BIAS    = 32'd32768;
    localparam logic [31:0] C_B7_SCALE   = 32'd50000;
    localparam logic [31:0] C_SIGN       = 32'h8000_0000;
    localparam logic [31:0] C_POLY_A     = 32'd3038;
    localparam logic [31:0] C_POLY_B     = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] C_POLY_C     = 32'd3791;

    // calibration words, already extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

endpackage

// File: rtl/bc_udiv.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bc_pkg; carries a sideband payload alongside each request.
`timescale 1ns / 1ps
module bc_udiv #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_num,
    input  logic [31:0]   i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [31:0]   o_quo,
    output logic [PW-1:0] o_pay
);
    import bc_pkg::*;

    logic          r_v   [C_DW];
    logic [31:0]   r_rem [C_DW];
    logic [31:0]   r_num [C_DW];
    logic [31:0]   r_den [C_DW];
    logic [31:0]   r_quo [C_DW];
    logic [PW-1:0] r_pay [C_DW];

    for (genvar k = 0; k < C_DW; k++) begin : g_stage
        logic          v_in;
        logic [31:0]   rem_in, num_in, den_in, quo_in;
        logic [PW-1:0] pay_in;
        logic [32:0]   sh;
        logic          ge;
        logic [32:0]   diff;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign pay_in = i_pay;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign pay_in = r_pay[k-1];
        end

        assign sh   = {rem_in, num_in[31]};
        assign diff = sh - {1'b0, den_in};
        assign ge   = (sh >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[31:0] : sh[31:0];
                r_num[k] <= {num_in[30:0], 1'b0};
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[30:0], ge};
                r_pay[k] <= pay_in;
            end
        end
    end

    assign o_valid = r_v[C_DW-1];
    assign o_quo   = r_quo[C_DW-1];
    assign o_pay   = r_pay[C_DW-1];

endmodule

// File: rtl/bc_temp.sv
// Temperature front end: X1, signed division by X1 + md, and B5.
// Depends on bc_pkg and bc_udiv.
`timescale 1ns / 1ps
module bc_temp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [15:0]   i_ut,
    input  logic [18:0]   i_up,
    input  bc_pkg::t_cal  i_cal,
    output logic          o_valid,
    output logic [31:0]   o_b5,
    output logic [18:0]   o_up,
    output logic          o_fault
);
    import bc_pkg::*;

    localparam int PW = 1 + 32 + 19 + 1;

    logic        r1_v, r2_v, r3_v;
    logic [31:0] r1_prod;
    logic [18:0] r1_up;
    logic [31:0] r2_ua, r2_ub, r2_x1;
    logic        r2_neg, r2_f;
    logic [18:0] r2_up;
    logic [31:0] r3_b5;
    logic [18:0] r3_up;
    logic        r3_f;

    logic [31:0] x1, den, num;
    logic        dv_v;
    logic [31:0] dv_q, q_s;
    logic [PW-1:0] dv_pay;
    logic        d_neg, d_f;
    logic [31:0] d_x1;
    logic [18:0] d_up;

    assign x1  = 32'($signed(r1_prod) >>> 15);
    assign den = x1 + i_cal.md;
    assign num = {i_cal.mc[20:0], 11'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= ({16'b0, i_ut} - i_cal.ac6) * i_cal.ac5;
            r1_up   <= i_up;
            r2_x1   <= x1;
            r2_ua   <= num[31] ? (32'd0 - num) : num;
            r2_ub   <= den[31] ? (32'd0 - den) : den;
            r2_neg  <= num[31] ^ den[31];
            r2_f    <= (den == 32'd0);
            r2_up   <= r1_up;
            r3_b5   <= d_x1 + q_s;
            r3_up   <= d_up;
            r3_f    <= d_f;
        end
    end

    bc_udiv #(.PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r2_v),
        .i_num   (r2_ua),
        .i_den   (r2_ub),
        .i_pay   ({r2_neg, r2_x1, r2_up, r2_f}),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_pay   (dv_pay)
    );

    assign {d_neg, d_x1, d_up, d_f} = dv_pay;
    assign q_s = d_neg ? (32'd0 - dv_q) : dv_q;

    assign o_valid = r3_v;
    assign o_b5    = r3_b5;
    assign o_up    = r3_up;
    assign o_fault = r3_f;

endmodule

// File: rtl/bc_press.sv
// Pressure back end: B6..B7, unsigned division by B4, final polynomial.
// Depends on bc_pkg and bc_udiv; last stage is the result register.
`timescale 1ns / 1ps
module bc_press (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_b5,
    input  logic [18:0]   i_up,
    input  logic          i_fault,
    input  bc_pkg::t_cal  i_cal,
    output logic          o_valid,
    output logic [15:0]   o_temp,
    output logic [31:0]   o_press,
    output logic          o_fault
);
    import bc_pkg::*;

    localparam int PW = 16 + 1 + 1;

    logic [11:1] r_v;
    logic [15:0] r_temp [1:6];
    logic [18:0] r_up   [1:4];
    logic        r_f    [1:6];

    logic [31:0] r1_b6;
    logic [31:0] r2_sq, r2_ac2, r2_ac3;
    logic [31:0] r3_x2a, r3_x1b, r3_b2sq, r3_b1sq;
    logic [31:0] r4_b3, r4_t;
    logic [31:0] r5_b4p, r5_b7p;
    logic [31:0] r6_b4, r6_b7;

    logic [31:0] r8_p, r9_p, r9_aa, r9_pm, r10_p, r10_m, r10_x2;
    logic [15:0] r8_temp, r9_temp, r10_temp, r11_temp;
    logic        r8_f, r9_f, r10_f, r11_f;
    logic [31:0] r11_p;

    logic [31:0] temp_full, sq, p3_x1, p4_x3, p4_s, p4_x2, p4_x3b, b4;
    logic [31:0] a8, x1f, pf;
    logic        shl;
    logic        dv_v, d_shl, d_f;
    logic [31:0] dv_q;
    logic [15:0] d_temp;
    logic [PW-1:0] dv_pay;

    assign temp_full = 32'($signed(i_b5 + 32'd8) >>> 4);
    assign sq     = 32'($signed(r2_sq) >>> 12);
    assign p3_x1  = 32'($signed(r3_b2sq) >>> 11);
    assign p4_x3  = p3_x1 + r3_x2a;
    assign p4_s   = ({i_cal.ac1[29:0], 2'b00} + p4_x3) << i_cal.oss;
    assign p4_x2  = 32'($signed(r3_b1sq) >>> 16);
    assign p4_x3b = 32'($signed(r3_x1b + p4_x2 + 32'd2) >>> 2);
    assign b4     = r5_b4p >> 15;
    // divide first and double after when B7 has its top bit set
    assign shl    = (r6_b7 >= C_SIGN);
    assign a8     = 32'($signed(r8_p) >>> 8);
    assign x1f    = 32'($signed(r10_m) >>> 16);
    assign pf     = r10_p + 32'($signed(x1f + r10_x2 + C_POLY_C) >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v[1]  <= i_valid;
            r_v[2]  <= r_v[1];
            r_v[3]  <= r_v[2];
            r_v[4]  <= r_v[3];
            r_v[5]  <= r_v[4];
            r_v[6]  <= r_v[5];
            r_v[7]  <= 1'b0;
            r_v[8]  <= dv_v;
            r_v[9]  <= r_v[8];
            r_v[10] <= r_v[9];
            r_v[11] <= r_v[10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_b6     <= i_b5 - C_B6_OFFSET;
            r_temp[1] <= temp_full[15:0];
            r_up[1]   <= i_up;
            r_f[1]    <= i_fault;

            r2_sq     <= r1_b6 * r1_b6;
            r2_ac2    <= i_cal.ac2 * r1_b6;
            r2_ac3    <= i_cal.ac3 * r1_b6;
            r_temp[2] <= r_temp[1];
            r_up[2]   <= r_up[1];
            r_f[2]    <= r_f[1];

            r3_x2a    <= 32'($signed(r2_ac2) >>> 11);
            r3_x1b    <= 32'($signed(r2_ac3) >>> 13);
            r3_b2sq   <= i_cal.b2 * sq;
            r3_b1sq   <= i_cal.b1 * sq;
            r_temp[3] <= r_temp[2];
            r_up[3]   <= r_up[2];
            r_f[3]    <= r_f[2];

            r4_b3     <= 32'($signed(p4_s + 32'd2) >>> 2);
            r4_t      <= p4_x3b + C_B4_BIAS;
            r_temp[4] <= r_temp[3];
            r_up[4]   <= r_up[3];
            r_f[4]    <= r_f[3];

            r5_b4p    <= i_cal.ac4 * r4_t;
            r5_b7p    <= {13'b0, r_up[4]} - r4_b3;
            r_temp[5] <= r_temp[4];
            r_f[5]    <= r_f[4];

            r6_b4     <= b4;
            r6_b7     <= r5_b7p * (C_B7_SCALE >> i_cal.oss);
            r_temp[6] <= r_temp[5];
            r_f[6]    <= r_f[5] | (b4 == 32'd0);

            r8_p      <= d_shl ? {dv_q[30:0], 1'b0} : dv_q;
            r8_temp   <= d_temp;
            r8_f      <= d_f;

            r9_p      <= r8_p;
            r9_aa     <= a8 * a8;
            r9_pm     <= r8_p * C_POLY_B;
            r9_temp   <= r8_temp;
            r9_f      <= r8_f;

            r10_p     <= r9_p;
            r10_m     <= r9_aa * C_POLY_A;
            r10_x2    <= 32'($signed(r9_pm) >>> 16);
            r10_temp  <= r9_temp;
            r10_f     <= r9_f;

            // zero both results on a divide fault
            r11_p     <= r10_f ? 32'd0 : pf;
            r11_temp  <= r10_f ? 16'd0 : r10_temp;
            r11_f     <= r10_f;
        end
    end

    bc_udiv #(.PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v[6]),
        .i_num   (shl ? r6_b7 : {r6_b7[30:0], 1'b0}),
        .i_den   (r6_b4),
        .i_pay   ({r_temp[6], shl, r_f[6]}),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_pay   (dv_pay)
    );

    assign {d_temp, d_shl, d_f} = dv_pay;

    assign o_valid = r_v[11];
    assign o_temp  = r11_temp;
    assign o_press = r11_p;
    assign o_fault = r11_f;

endmodule

// File: rtl/barometric_compensation.sv
// Barometric compensation: temperature and pressure correction pipeline.
// Usage:
//   Input stream s_axis carries one raw temperature and one raw pressure word
//   per request. Output stream m_axis returns one result per request: the
//   temperature in tenths of a degree, the pressure in pascals and a fault
//   flag set when a divisor was zero (both results are then zero).
//   Calibration words and the oversampling setting are loaded through the
//   write port (i_cfg_wr_en, i_cfg_index, i_cfg_data); the user must do so
//   only while no request is in flight, which the block does not enforce; unknown indexes are dropped.
// Timing:
//   The temperature section is a 32-stage divider plus three stages, and the
//   pressure section is a second 32-stage divider plus ten stages.
//   Throughput is one request per cycle while the output is not stalled; each
//   divider retires one quotient bit per stage.
// Reset and stall:
//   Reset clears all valid bits and the calibration registers to zero.
//   The whole pipeline advances together; while a result waits on
//   m_axis_tready the pipeline holds and s_axis_tready is low, so no
//   request is lost or repeated.
// Depends on bc_pkg, bc_udiv, bc_temp and bc_press.
`timescale 1ns / 1ps
module barometric_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temperature[15:0], raw_pressure[34:16], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // temperature_tenths[15:0], pressure_pa[47:16],
                                       // divide_fault[48], zero pad
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import bc_pkg::*;

    logic [47:0] r_cal_a, r_cal_u;
    logic [31:0] r_cal_b, r_cal_m;
    logic [1:0]  r_oss;
    t_cal        cal;

    logic        en;
    logic        t_v, t_f;
    logic [31:0] t_b5;
    logic [18:0] t_up;
    logic [15:0] o_temp;
    logic [31:0] o_press;
    logic        o_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_u <= '0;
            r_cal_b <= '0;
            r_cal_m <= '0;
            r_oss   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                C_REG_CAL_A: r_cal_a <= i_cfg_data;
                C_REG_CAL_U: r_cal_u <= i_cfg_data;
                C_REG_CAL_B: r_cal_b <= i_cfg_data[31:0];
                C_REG_CAL_M: r_cal_m <= i_cfg_data[31:0];
                C_REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = {{16{r_cal_a[15]}}, r_cal_a[15:0]};
        cal.ac2 = {{16{r_cal_a[31]}}, r_cal_a[31:16]};
        cal.ac3 = {{16{r_cal_a[47]}}, r_cal_a[47:32]};
        cal.ac4 = {16'b0, r_cal_u[15:0]};
        cal.ac5 = {16'b0, r_cal_u[31:16]};
        cal.ac6 = {16'b0, r_cal_u[47:32]};
        cal.b1  = {{16{r_cal_b[15]}}, r_cal_b[15:0]};
        cal.b2  = {{16{r_cal_b[31]}}, r_cal_b[31:16]};
        cal.mc  = {{16{r_cal_m[15]}}, r_cal_m[15:0]};
        cal.md  = {{16{r_cal_m[31]}}, r_cal_m[31:16]};
        cal.oss = r_oss;
    end

    // advance everything unless a finished result is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    bc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_ut    (s_axis_tdata[15:0]),
        .i_up    (s_axis_tdata[34:16]),
        .i_cal   (cal),
        .o_valid (t_v),
        .o_b5    (t_b5),
        .o_up    (t_up),
        .o_fault (t_f)
    );

    bc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (t_v),
        .i_b5    (t_b5),
        .i_up    (t_up),
        .i_fault (t_f),
        .i_cal   (cal),
        .o_valid (m_axis_tvalid),
        .o_temp  (o_temp),
        .o_press (o_press),
        .o_fault (o_fault)
    );

    assign m_axis_tdata = {7'b0, o_fault, o_press, o_temp};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for barometric_compensation: drives raw readings and
// calibration words, predicts each compensated reading and checks every result.
// Depends on bc_pkg and the barometric_compensation RTL.
`timescale 1ns / 1ps
module tb_top;
    import bc_pkg::*;

    localparam logic [2:0] C_REG_UNUSED = 3'd7;
    localparam int         C_DRAIN      = 100;
    localparam int         C_HANG_LIMIT = 5000;

    typedef struct packed {
        logic [15:0] tenths;
        logic [31:0] pa;
        logic        fault;
    } t_reading;

    class reading_scoreboard;
        t_reading    expected_readings[$];
        int          errors;
        logic [47:0] cal_a, cal_u;
        logic [31:0] cal_b, cal_m;
        logic [1:0]  oss;

        function new();
            errors = 0;
            cal_a = '0; cal_u = '0; cal_b = '0; cal_m = '0; oss = '0;
        endfunction

        function void load_register(logic [2:0] idx, logic [47:0] data);
            case (idx)
                C_REG_CAL_A: cal_a = data;
                C_REG_CAL_U: cal_u = data;
                C_REG_CAL_B: cal_b = data[31:0];
                C_REG_CAL_M: cal_m = data[31:0];
                C_REG_OSS:   oss   = data[1:0];
                default: ;
            endcase
        endfunction

        static function logic [31:0] sext(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        static function logic [31:0] asr(logic [31:0] x, int n);
            return $signed(x) >>> n;
        endfunction

        // truncating signed divide; the overflow case wraps
        static function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
            logic [31:0] ua, ub, q;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q  = ua / ub;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function t_reading compensate(logic [15:0] ut, logic [18:0] up);
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] x1, x2, x3, den, b5, temp, b6, sq, b3, b4, b7, p, t;
            t_reading r;
            ac1 = sext(cal_a[15:0]); ac2 = sext(cal_a[31:16]); ac3 = sext(cal_a[47:32]);
            ac4 = {16'd0, cal_u[15:0]}; ac5 = {16'd0, cal_u[31:16]};
            ac6 = {16'd0, cal_u[47:32]};
            b1 = sext(cal_b[15:0]); b2 = sext(cal_b[31:16]);
            mc = sext(cal_m[15:0]); md = sext(cal_m[31:16]);
            r = '0;
            r.fault = 1'b1;
            t = ({16'd0, ut} - ac6) * ac5;
            x1 = asr(t, 15);
            den = x1 + md;
            if (den == 0) return r;
            x2 = sdiv(mc << 11, den);
            b5 = x1 + x2;
            temp = asr(b5 + 32'd8, 4);
            b6 = b5 - C_B6_OFFSET;
            t = b6 * b6;
            sq = asr(t, 12);
            t = b2 * sq;
            x1 = asr(t, 11);
            t = ac2 * b6;
            x2 = asr(t, 11);
            x3 = x1 + x2;
            t = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
            b3 = asr(t, 2);
            t = ac3 * b6;
            x1 = asr(t, 13);
            t = b1 * sq;
            x2 = asr(t, 16);
            x3 = asr(x1 + x2 + 32'd2, 2);
            t = ac4 * (x3 + C_B4_BIAS);
            b4 = t >> 15;
            if (b4 == 0) return r;
            t = C_B7_SCALE >> oss;
            b7 = ({13'd0, up} - b3) * t;
            if (b7 < C_SIGN) begin
                t = b7 << 1;
                p = t / b4;
            end else begin
                t = b7 / b4;
                p = t << 1;
            end
            x1 = asr(p, 8) * asr(p, 8);
            t = x1 * C_POLY_A;
            x1 = asr(t, 16);
            t = p * C_POLY_B;
            x2 = asr(t, 16);
            p = p + asr(x1 + x2 + C_POLY_C, 4);
            r.tenths = temp[15:0];
            r.pa     = p;
            r.fault  = 1'b0;
            return r;
        endfunction

        function void note_request(logic [15:0] ut, logic [18:0] up);
            expected_readings.push_back(compensate(ut, up));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h, want %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [55:0] data);
            t_reading e;
            if (expected_readings.size() == 0) begin
                report("unexpected result", data[31:0], '0);
                return;
            end
            e = expected_readings.pop_front();
            if (data[15:0] !== e.tenths)
                report("temperature_tenths", 32'(data[15:0]), 32'(e.tenths));
            if (data[47:16] !== e.pa) report("pressure_pa", data[47:16], e.pa);
            if (data[48] !== e.fault)
                report("divide_fault", 32'(data[48]), 32'(e.fault));
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [39:0] s_axis_tdata;   // raw_temperature[15:0], raw_pressure[34:16], zero pad
    logic        m_axis_tvalid, m_axis_tready;
    logic [55:0] m_axis_tdata;   // temperature_tenths[15:0], pressure_pa[47:16],
                                 // divide_fault[48], zero pad
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    reading_scoreboard sb = new();
    bit calm;      // no idling on either side
    int hang;

    barometric_compensation DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check, stall in bursts, watch for a hang
    initial begin
        int stall;
        stall = 0;
        hang = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                hang = 0;
            else
                hang++;
            if (hang >= C_HANG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (stall > 0) stall--;
            else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 9);
            m_axis_tready <= (stall == 0);
        end
    end

    task automatic send_reading(logic [15:0] ut, logic [18:0] up);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up, ut};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(ut, up);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (C_DRAIN) @(posedge i_clk);
    endtask

    // load all registers on consecutive cycles, plus a write to an unused index
    task automatic load_cal(logic [47:0] a, logic [47:0] u, logic [31:0] b,
                            logic [31:0] m, logic [1:0] o);
        logic [2:0]  idx [6];
        logic [47:0] val [6];
        idx = '{C_REG_CAL_A, C_REG_CAL_U, C_REG_CAL_B, C_REG_CAL_M, C_REG_OSS, C_REG_UNUSED};
        val = '{a, u, {16'd0, b}, {16'd0, m}, {46'd0, o}, 48'({$urandom, $urandom})};
        for (int k = 0; k < 6; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.load_register(idx[k], val[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // typical calibration set with optional jitter on each word
    task automatic load_typical(logic [1:0] o, bit jitter);
        logic [15:0] w [10];
        w = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
              16'd6190, 16'd4, -16'sd8711, 16'd2868};
        if (jitter)
            for (int k = 0; k < 10; k++) w[k] = w[k] + 16'($urandom_range(0, 511) - 256);
        load_cal({w[2], w[1], w[0]}, {w[5], w[4], w[3]}, {w[7], w[6]}, {w[9], w[8]}, o);
    endtask

    initial begin
        logic [15:0] ut;
        logic [18:0] up;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = C_REG_CAL_A;
        i_cfg_data = '0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero calibration: temperature divisor is zero
        send_reading(16'd27898, 19'd23843);
        send_reading(16'hFFFF, 19'h7FFFF);
        wait_idle();
        // typical set across every oversampling setting and the input extremes
        for (int o = 0; o < 4; o++) begin
            load_typical(2'(o), 1'b0);
            send_reading(16'd27898, 19'd23843);
            send_reading(16'd0, 19'd0);
            send_reading(16'hFFFF, 19'h7FFFF);
            send_reading(16'd0, 19'h7FFFF);
            send_reading(16'hFFFF, 19'd0);
            wait_idle();
        end
        // ac4 of zero: pressure divisor is zero
        load_cal({16'hC7CF, 16'hFFB8, 16'd408}, {16'd23153, 16'd32757, 16'd0},
                 {16'd4, 16'd6190}, {16'd2868, 16'hDDF9}, 2'd0);
        send_reading(16'd27898, 19'd23843);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: load_typical(2'(ph / 2), 1'b1);
                1: load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            $urandom, $urandom, 2'($urandom));
                2: load_cal('1, '1, '1, '1, 2'd3);
                default: load_typical(2'($urandom), 1'b1);
            endcase
            calm = (ph == 7);
            for (int n = 0; n < 210; n++) begin
                ut = ph[0] ? 16'($urandom) : 16'($urandom_range(20000, 36000));
                up = ph[0] ? 19'($urandom) : 19'($urandom_range(15000, 45000) << (ph / 2));
                send_reading(ut, up);
                // let the pipeline run dry once mid-phase
                if (ph == 3 && n == 100) wait_idle();
            end
            wait_idle();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
rtl/bc_pkg.sv
rtl/bc_udiv.sv
rtl/bc_temp.sv
rtl/bc_press.sv
rtl/barometric_compensation.sv
tb/tb_top.sv
